// ----- rtl/vln_pkg.sv -----
package vln_pkg;

	// defaults of the top level parameters
	localparam int unsigned MAX_LENGTH_DEF = 64;
	localparam int unsigned ELEM_WIDTH_DEF = 16;

	// configuration port geometry
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	// vector_length register
	localparam int unsigned VLEN_WIDTH = 7;
	localparam int unsigned VLEN_MAX   = (1 << VLEN_WIDTH) - 1;

	localparam logic [VLEN_WIDTH-1:0] VLEN_RESET   = VLEN_WIDTH'(64);
	localparam logic                  NORM_EN_RESET = 1'b1;

endpackage

// ----- rtl/vln_if.sv -----
interface vln_elem_if #(
	parameter int unsigned ELEM_WIDTH = vln_pkg::ELEM_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [ELEM_WIDTH-1:0] element_value;

	modport source (output valid, output element_value, input ready);
	modport sink   (input valid, input element_value, output ready);
endinterface

interface vln_res_if #(
	parameter int unsigned ELEM_WIDTH = vln_pkg::ELEM_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [ELEM_WIDTH-1:0] scaled_value;
	logic                         last_of_vector;

	modport source (output valid, output scaled_value, output last_of_vector, input ready);
	modport sink   (input valid, input scaled_value, input last_of_vector, output ready);
endinterface

// ----- rtl/vln_isqrt.sv -----
module vln_isqrt #(
	parameter int unsigned IN_W = 37
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [IN_W-1:0]         radicand,
	output logic                    done,
	output logic [(IN_W+1)/2-1:0]   root
);

	localparam int unsigned OUT_W = (IN_W + 1) / 2;
	localparam int unsigned RAD_W = 2 * OUT_W;
	localparam int unsigned REM_W = OUT_W + 2;
	localparam int unsigned CNT_W = $clog2(OUT_W);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [OUT_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             take;
	logic [REM_W-1:0] rem_nx;

	// one result bit per cycle, two radicand bits shifted in
	always_comb begin
		rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial  = (REM_W + 2)'({root_q, 2'b01});
		take   = (rem_sh >= trial);
		rem_nx = take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q  <= '0;
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q  <= RAD_W'(radicand);
				rem_q  <= '0;
				root_q <= '0;
				cnt_q  <= CNT_W'(OUT_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				rem_q  <= rem_nx;
				root_q <= {root_q[OUT_W-2:0], take};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- rtl/vln_div.sv -----
module vln_div #(
	parameter int unsigned MAG_W  = 16,
	parameter int unsigned NORM_W = 19
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [MAG_W-1:0]  mag,
	input  logic [NORM_W-1:0] norm,
	output logic              done,
	output logic [MAG_W-1:0]  quotient
);

	// quotient of (mag << (MAG_W-1)) / norm, all ones when it needs more than MAG_W bits
	localparam int unsigned CNT_W = $clog2(MAG_W);

	logic [NORM_W-1:0] rem_q;
	logic [MAG_W-1:0]  sh_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic              too_big;
	logic [NORM_W:0]   rem_sh;
	logic              take;
	logic [NORM_W:0]   rem_diff;

	always_comb begin
		too_big  = ((NORM_W + 1)'(mag) >= {norm, 1'b0});
		rem_sh   = {rem_q, sh_q[MAG_W-1]};
		take     = (rem_sh >= (NORM_W + 1)'(norm));
		rem_diff = rem_sh - (NORM_W + 1)'(norm);
	end

	// restoring division, one quotient bit per cycle; quotient bits shift in behind
	// the dividend bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			sh_q   <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (too_big) begin
					sh_q   <= '1;
					done_q <= 1'b1;
				end else begin
					rem_q  <= NORM_W'(mag >> 1);
					sh_q   <= {mag[0], {(MAG_W-1){1'b0}}};
					cnt_q  <= CNT_W'(MAG_W - 1);
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				rem_q <= take ? rem_diff[NORM_W-1:0] : rem_sh[NORM_W-1:0];
				sh_q  <= {sh_q[MAG_W-2:0], take};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

// ----- rtl/vector_l2_normalizer.sv -----
// channel   dir  payload                          beat taken when
// element   in   element_value                    element.valid && element.ready
// result    out  scaled_value, last_of_vector     result.valid && result.ready
// apb       in   vector_length, normalize_enable  psel && penable && pwrite (pready high)
//
// pass-through: one element per cycle while result.ready is high; the output register frees the input side
// normalizing, fill: each element is stored, squared, then accumulated
// normalizing, drain: the bit-serial square root, then for each element a store read,
//   a scale by the bit-serial divider and an emit
// reset clears all but the store and its read data; only fresh store entries are read
// a result stalled on result.ready holds the drain; element.ready is low while busy
module vector_l2_normalizer #(
	parameter int unsigned MAX_LENGTH = vln_pkg::MAX_LENGTH_DEF,
	parameter int unsigned ELEM_WIDTH = vln_pkg::ELEM_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	vln_elem_if.sink                            element,
	vln_res_if.source                           result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [vln_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [vln_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [vln_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	import vln_pkg::*;

	// longest vector actually reachable through the 7-bit length register
	localparam int unsigned EFF_MAX = (MAX_LENGTH < VLEN_MAX) ? MAX_LENGTH : VLEN_MAX;
	localparam int unsigned IDX_W   = $clog2(MAX_LENGTH);
	localparam int unsigned LEN_W   = $clog2(EFF_MAX + 1);
	localparam int unsigned CMP_W   = (LEN_W > IDX_W) ? LEN_W : IDX_W;
	localparam int unsigned SQ_W    = 2 * ELEM_WIDTH - 1;
	// sum of squares, capped at 64 bits where it saturates
	localparam int unsigned SUM_RAW = 2 * ELEM_WIDTH - 2 + $clog2(EFF_MAX + 1);
	localparam int unsigned SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
	localparam int unsigned NORM_W  = (SUM_W + 1) / 2;

	// register decode on paddr[2]
	localparam logic REG_VECTOR_LENGTH    = 1'b0;
	localparam logic REG_NORMALIZE_ENABLE = 1'b1;

	localparam logic [ELEM_WIDTH-1:0] HALF = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQR,
		ST_ACC,
		ST_ROOT_GO,
		ST_ROOT,
		ST_READ,
		ST_SCALE,
		ST_DIVW,
		ST_EMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [VLEN_WIDTH-1:0] vector_length_q;
	logic                  normalize_enable_q;
	logic                  cfg_wr;

	// datapath and control registers
	logic [IDX_W-1:0]             idx_q;
	logic [IDX_W-1:0]             rd_idx_q;
	logic [SUM_W-1:0]             sum_q;
	logic [ELEM_WIDTH-1:0]        mag_q;
	logic [SQ_W-1:0]              sq_q;
	logic                         last_q;
	logic [NORM_W-1:0]            norm_q;
	logic signed [ELEM_WIDTH-1:0] res_q;
	logic signed [ELEM_WIDTH-1:0] rd_data_q;

	// output register
	logic                         out_valid_q;
	logic signed [ELEM_WIDTH-1:0] out_value_q;
	logic                         out_last_q;

	// element store
	logic signed [ELEM_WIDTH-1:0] mem [MAX_LENGTH];

	logic [LEN_W-1:0]        len_eff;
	logic [CMP_W-1:0]        last_idx;
	logic                    in_last;
	logic                    rd_last;
	logic                    out_free;
	logic                    out_load;
	logic                    in_take;
	logic                    mem_we;
	logic [ELEM_WIDTH-1:0]   in_mag;
	logic [ELEM_WIDTH-1:0]   rd_mag;
	logic                    rd_neg;
	logic [2*ELEM_WIDTH-1:0] prod;
	logic [SUM_W:0]          sum_add;
	logic [SUM_W-1:0]        sum_nx;
	logic                    root_start;
	logic                    root_done;
	logic [NORM_W-1:0]       root;
	logic                    div_start;
	logic                    div_done;
	logic [ELEM_WIDTH-1:0]   quot;
	logic [ELEM_WIDTH-1:0]   scaled;

	// ---------------------------------------------------------------- config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_length_q    <= VLEN_RESET;
			normalize_enable_q <= NORM_EN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_VECTOR_LENGTH:    vector_length_q    <= pwdata[VLEN_WIDTH-1:0];
				REG_NORMALIZE_ENABLE: normalize_enable_q <= pwdata[0];
				default:              ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_VECTOR_LENGTH:    prdata = APB_DATA_W'(vector_length_q);
			REG_NORMALIZE_ENABLE: prdata = APB_DATA_W'(normalize_enable_q);
			default:              prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- length and position
	// zero length acts as one, anything past the store depth is clipped
	always_comb begin
		if (vector_length_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (int'(vector_length_q) > MAX_LENGTH) begin
			len_eff = LEN_W'(MAX_LENGTH);
		end else begin
			len_eff = LEN_W'(vector_length_q);
		end
		last_idx = CMP_W'(len_eff) - 1'b1;
		in_last  = (CMP_W'(idx_q) == last_idx);
		rd_last  = (CMP_W'(rd_idx_q) == last_idx);
	end

	// ---------------------------------------------------------------- handshake
	assign out_free      = !out_valid_q || result.ready;
	assign element.ready = (state_q == ST_IDLE) && out_free;
	assign in_take       = element.valid && element.ready;
	assign mem_we        = in_take && normalize_enable_q;
	// output register takes a new beat this cycle
	assign out_load      = ((state_q == ST_IDLE) && !cfg_wr && in_take && !normalize_enable_q)
		|| ((state_q == ST_EMIT) && out_free);

	assign result.valid          = out_valid_q;
	assign result.scaled_value   = out_value_q;
	assign result.last_of_vector = out_last_q;

	// ---------------------------------------------------------------- arithmetic
	always_comb begin
		in_mag = element.element_value[ELEM_WIDTH-1] ?
			ELEM_WIDTH'(-element.element_value) : ELEM_WIDTH'(element.element_value);
		rd_neg = rd_data_q[ELEM_WIDTH-1];
		rd_mag = rd_neg ? ELEM_WIDTH'(-rd_data_q) : ELEM_WIDTH'(rd_data_q);
		prod   = mag_q * mag_q;
		// saturating accumulate
		sum_add = {1'b0, sum_q} + (SUM_W + 1)'(sq_q);
		sum_nx  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
		// truncated quotient back to a signed value, saturated at both ends
		if (rd_neg) begin
			scaled = (quot > HALF) ? HALF : ELEM_WIDTH'(-quot);
		end else begin
			scaled = (quot >= HALF) ? ~HALF : quot;
		end
	end

	assign root_start = (state_q == ST_ROOT_GO);
	assign div_start  = (state_q == ST_SCALE) && (norm_q != '0);

	vln_isqrt #(
		.IN_W (SUM_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sum_q),
		.done     (root_done),
		.root     (root)
	);

	vln_div #(
		.MAG_W  (ELEM_WIDTH),
		.NORM_W (NORM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.mag      (rd_mag),
		.norm     (norm_q),
		.done     (div_done),
		.quotient (quot)
	);

	// ---------------------------------------------------------------- element store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= element.element_value;
		end
		rd_data_q <= mem[rd_idx_q];
	end

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			rd_idx_q    <= '0;
			sum_q       <= '0;
			mag_q       <= '0;
			sq_q        <= '0;
			last_q      <= 1'b0;
			norm_q      <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_valid_q && result.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_wr) begin
						// a register write while idle drops a partial vector
						idx_q <= '0;
						sum_q <= '0;
					end else if (in_take) begin
						if (!normalize_enable_q) begin
							out_valid_q <= 1'b1;
							out_value_q <= element.element_value;
							out_last_q  <= in_last;
							idx_q       <= in_last ? '0 : idx_q + 1'b1;
						end else begin
							mag_q   <= in_mag;
							last_q  <= in_last;
							state_q <= ST_SQR;
						end
					end
				end
				ST_SQR: begin
					sq_q    <= prod[SQ_W-1:0];
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q <= sum_nx;
					if (last_q) begin
						state_q <= ST_ROOT_GO;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_ROOT_GO: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done) begin
						norm_q   <= root;
						rd_idx_q <= '0;
						state_q  <= ST_READ;
					end
				end
				ST_READ: begin
					// store read address settles, data registered next cycle
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (norm_q == '0) begin
						// zero vector goes out unchanged
						res_q   <= rd_data_q;
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_done) begin
						res_q   <= scaled;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_value_q <= res_q;
						out_last_q  <= rd_last;
						if (rd_last) begin
							idx_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
							state_q  <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------- checks
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVW)
		else $error("divider finished outside of its wait state");

	a_root_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == ST_ROOT)
		else $error("square root finished outside of its wait state");

	a_drain_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_SCALE || state_q == ST_DIVW
			|| state_q == ST_EMIT) |-> CMP_W'(rd_idx_q) <= last_idx)
		else $error("drain index ran past the vector end");

	a_no_drain_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> state_q == ST_IDLE && normalize_enable_q)
		else $error("store written while a vector drains");

endmodule
